### src/lcg_random_in_range_unit_defines.svh
// Assertion macros used by the checker of the random-in-range unit.
`ifndef LCG_RANDOM_IN_RANGE_UNIT_DEFINES_SVH
`define LCG_RANDOM_IN_RANGE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LCGR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcgr assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define LCGR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcgr assertion failed");

`endif

### src/lcgr_pkg.sv
// Package with constants and types of the random-in-range unit.
`default_nettype none
package lcgr_pkg;

  localparam int SEED_W  = 31;
  localparam int DATA_W  = 32;
  localparam int RANGE_W = 33;
  localparam int CNT_W   = $clog2(SEED_W + 1);

  localparam logic [SEED_W-1:0] LCG_MUL   = 31'd1103515245;
  localparam logic [SEED_W-1:0] LCG_INC   = 31'd12345;
  localparam logic [SEED_W-1:0] SEED_INIT = 31'd1;

  localparam logic REQ_DRAW   = 1'b0;
  localparam logic REQ_RESEED = 1'b1;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic done;
  } div_sts_t;

endpackage
`default_nettype wire

### src/lcg_random_in_range_unit.sv
// Draw: one item at a time. The seed update (a multiply state, then an add state)
// comes ahead of the 31-step serial divider for seed mod range, which is followed
// by a finish state that places the result beat.
// The next beat can be taken at the edge the result leaves.
// Reseed and reversed bounds: the result beat shows in the cycle after the input beat.
// Synchronous active-low reset: seed returns to one, control and output valid clear.
`default_nettype none
module lcg_random_in_range_unit
  import lcgr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_req_type,
  input  wire logic signed [DATA_W-1:0] in_lower_bound,
  input  wire logic signed [DATA_W-1:0] in_upper_bound,
  input  wire logic signed [DATA_W-1:0] in_new_seed,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      out_random_value,
  output logic                          out_range_error
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_SEED = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [SEED_W-1:0]  seed_r, seed_nxt;
  logic [SEED_W-1:0]  prod_r, prod_nxt;
  logic [DATA_W-1:0]  lo_r, lo_nxt;
  logic [RANGE_W-1:0] range_r, range_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  value_r, value_nxt;
  logic               err_r, err_nxt;

  logic               out_free;
  logic               in_acc;
  logic [SEED_W-1:0]  seed_adv;
  logic [RANGE_W-1:0] range_calc;
  div_ctl_t           div_ctl;
  div_sts_t           div_sts;
  logic [SEED_W-1:0]  div_rem;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign seed_adv = prod_r + LCG_INC;

  // Inclusive range in 33 bits: 1 up to 2^32 when the bounds are in order.
  assign range_calc = {in_upper_bound[DATA_W-1], in_upper_bound}
                    - {in_lower_bound[DATA_W-1], in_lower_bound} + RANGE_W'(1);

  lcgr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (seed_adv),
    .divisor   (range_r),
    .sts       (div_sts),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    seed_nxt      = seed_r;
    prod_nxt      = prod_r;
    lo_nxt        = lo_r;
    range_nxt     = range_r;
    out_valid_nxt = out_valid_r && out_stall;
    value_nxt     = value_r;
    err_nxt       = err_r;
    div_ctl.start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_req_type == REQ_RESEED) begin
            seed_nxt      = in_new_seed[SEED_W-1:0];
            out_valid_nxt = 1'b1;
            value_nxt     = '0;
            err_nxt       = 1'b0;
          end else if (in_lower_bound > in_upper_bound) begin
            out_valid_nxt = 1'b1;
            value_nxt     = '0;
            err_nxt       = 1'b1;
          end else begin
            lo_nxt    = in_lower_bound;
            range_nxt = range_calc;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        prod_nxt  = SEED_W'(seed_r * LCG_MUL);
        state_nxt = S_SEED;
      end
      S_SEED: begin
        seed_nxt      = seed_adv;
        div_ctl.start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (div_sts.done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          value_nxt     = lo_r + {1'b0, div_rem};
          err_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seed_r      <= SEED_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_r      <= seed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    prod_r  <= prod_nxt;
    lo_r    <= lo_nxt;
    range_r <= range_nxt;
    value_r <= value_nxt;
    err_r   <= err_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_random_value = value_r;
  assign out_range_error  = err_r;

endmodule
`default_nettype wire

### src/lcgr_div.sv
// Bit-serial restoring divider that yields the remainder of seed by range.
`default_nettype none
module lcgr_div
  import lcgr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire div_ctl_t           ctl,
  input  wire logic [SEED_W-1:0]  dividend,
  input  wire logic [RANGE_W-1:0] divisor,
  output div_sts_t                sts,
  output logic [SEED_W-1:0]       remainder
);

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               done_r, done_nxt;
  logic [SEED_W-1:0]  dvd_r, dvd_nxt;
  logic [SEED_W-1:0]  rem_r, rem_nxt;
  logic [RANGE_W-1:0] dvs_r, dvs_nxt;
  logic [SEED_W:0]    trial;
  logic               fits;

  // The partial remainder never exceeds the dividend prefix, so it stays
  // below 2^31 and the top bit of the trial value is always clear.
  assign trial = {rem_r, dvd_r[SEED_W-1]};
  assign fits  = ({1'b0, trial} >= dvs_r);

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (ctl.start) begin
      cnt_nxt = CNT_W'(SEED_W);
      dvd_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
      dvd_nxt  = {dvd_r[SEED_W-2:0], 1'b0};
      if (fits) begin
        rem_nxt = SEED_W'(({1'b0, trial} - dvs_r));
      end else begin
        rem_nxt = trial[SEED_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign sts.done  = done_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

### src/lcgr_checker.sv
// Port-level checker for the random-in-range unit, bound to the top level.
`default_nettype none
`include "lcg_random_in_range_unit_defines.svh"
module lcgr_checker
  import lcgr_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              in_req_type,
  input wire logic [DATA_W-1:0] in_lower_bound,
  input wire logic [DATA_W-1:0] in_upper_bound,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [DATA_W-1:0] out_random_value,
  input wire logic              out_range_error
);

  logic in_acc;
  logic draw_ok;

  assign in_acc  = in_valid && !in_stall;
  assign draw_ok = (in_req_type == REQ_DRAW)
                && ($signed(in_lower_bound) <= $signed(in_upper_bound));

  `LCGR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `LCGR_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall,
                    $stable(out_random_value) && $stable(out_range_error))
  `LCGR_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && out_range_error,
                   out_random_value == '0)
  `LCGR_ASSERT_NEXT(a_draw_busy, clk, rst_n, in_acc && draw_ok, in_stall)
  `LCGR_ASSERT_NEXT(a_quick_result, clk, rst_n, in_acc && !draw_ok, out_valid)

endmodule

bind lcg_random_in_range_unit lcgr_checker u_lcgr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_req_type      (in_req_type),
  .in_lower_bound   (in_lower_bound),
  .in_upper_bound   (in_upper_bound),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_random_value (out_random_value),
  .out_range_error  (out_range_error)
);
`default_nettype wire

### dv/lcg_random_in_range_unit_tb.sv
// Self-checking testbench for the LCG random-in-range unit.
`timescale 1ns / 1ps

module lcg_random_in_range_unit_tb;
  import lcgr_pkg::*;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_GAP      = 6;

  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     range_error;
  } draw_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_req_type = REQ_DRAW;
  logic signed [DATA_W-1:0] in_lower_bound = '0;
  logic signed [DATA_W-1:0] in_upper_bound = '0;
  logic signed [DATA_W-1:0] in_new_seed = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_random_value;
  logic                     out_range_error;

  logic [SEED_W-1:0] shadow_seed = SEED_INIT;
  draw_result_t      expected_draws[$];
  draw_result_t      head_draw;
  bit                burst_mode = 1'b0;
  int                fail_count = 0;
  int                results_checked = 0;
  int                draws_sent = 0;
  int                reversed_sent = 0;
  int                reseeds_sent = 0;
  int                cycle_count = 0;

  lcg_random_in_range_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_lower_bound   (in_lower_bound),
    .in_upper_bound   (in_upper_bound),
    .in_new_seed      (in_new_seed),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_random_value (out_random_value),
    .out_range_error  (out_range_error)
  );

  always #6 clk = ~clk;

  // Advances the shadow seed where the block would and returns the result beat.
  function automatic draw_result_t predict_draw(logic req, logic signed [DATA_W-1:0] lo,
                                                logic signed [DATA_W-1:0] hi,
                                                logic [DATA_W-1:0] seed_in);
    draw_result_t      res;
    logic [RANGE_W-1:0] span;
    logic [RANGE_W-1:0] offs;
    res = '0;
    if (req == REQ_RESEED) begin
      shadow_seed = seed_in[SEED_W-1:0];
    end else if (lo > hi) begin
      res.range_error = 1'b1;
    end else begin
      shadow_seed = shadow_seed * LCG_MUL + LCG_INC;
      // Inclusive span in 33 bits: 1 up to 2^32.
      span = {hi[DATA_W-1], hi} - {lo[DATA_W-1], lo} + 33'd1;
      offs = {2'b00, shadow_seed} % span;
      res.value = lo + offs[DATA_W-1:0];
    end
    return res;
  endfunction

  task automatic send_beat(logic req, logic signed [DATA_W-1:0] lo,
                           logic signed [DATA_W-1:0] hi, logic [DATA_W-1:0] seed_in);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_lower_bound <= lo;
    in_upper_bound <= hi;
    in_new_seed    <= seed_in;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_draws.push_back(predict_draw(req, lo, hi, seed_in));
    if (req == REQ_RESEED) reseeds_sent++;
    else draws_sent++;
    if (req == REQ_DRAW && lo > hi) reversed_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_draws.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] boundary_value(int k);
    case (k)
      0:       return S32_MIN;
      1:       return S32_MIN + 1;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      5:       return S32_MAX - 1;
      default: return S32_MAX;
    endcase
  endfunction

  task automatic test_draws_from_reset_seed();
    send_beat(REQ_DRAW, 0, 100, $urandom);
    send_beat(REQ_DRAW, -50, 50, $urandom);
    send_beat(REQ_DRAW, 0, 1, $urandom);
  endtask

  task automatic test_equal_bounds();
    send_beat(REQ_DRAW, 5, 5, '0);
    send_beat(REQ_DRAW, S32_MIN, S32_MIN, '1);
    send_beat(REQ_DRAW, S32_MAX, S32_MAX, '0);
  endtask

  task automatic test_wide_ranges();
    send_beat(REQ_DRAW, S32_MIN, S32_MAX, '1);
    send_beat(REQ_DRAW, S32_MIN, S32_MAX - 1, '0);
    send_beat(REQ_DRAW, 0, S32_MAX, '1);
    send_beat(REQ_DRAW, S32_MIN, -1, '0);
    send_beat(REQ_DRAW, -1, 0, '1);
  endtask

  task automatic test_reversed_bounds();
    send_beat(REQ_DRAW, 1, 0, '1);
    send_beat(REQ_DRAW, S32_MAX, S32_MIN, '0);
    send_beat(REQ_DRAW, 0, -1, '1);
    // The seed must not have moved on the errors above.
    send_beat(REQ_DRAW, 0, 1000, '0);
  endtask

  task automatic test_reseed();
    send_beat(REQ_RESEED, S32_MIN, S32_MAX, '0);
    send_beat(REQ_DRAW, -1000, 1000, '0);
    send_beat(REQ_RESEED, S32_MAX, S32_MIN, 32'hFFFF_FFFF);
    send_beat(REQ_DRAW, S32_MIN, S32_MAX, '0);
    send_beat(REQ_RESEED, 0, 0, 32'h8000_0000);
    send_beat(REQ_DRAW, 0, 9, 32'h7FFF_FFFF);
    send_beat(REQ_RESEED, 7, 3, 32'h7FFF_FFFF);
    send_beat(REQ_DRAW, S32_MIN, S32_MAX, 32'h8000_0000);
  endtask

  task automatic send_random_item();
    int                       sel;
    int                       k;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
    logic signed [DATA_W-1:0] tmp;
    sel = $urandom_range(0, 99);
    lo  = $urandom;
    hi  = $urandom;
    if (sel < 10) begin
      send_beat(REQ_RESEED, lo, hi, $urandom);
    end else if (sel < 20) begin
      if (lo < hi) begin
        tmp = lo; lo = hi; hi = tmp;
      end
      if (lo == hi) begin
        if (lo == S32_MAX) hi = lo - 1;
        else lo = lo + 1;
      end
      send_beat(REQ_DRAW, lo, hi, $urandom);
    end else begin
      if (sel < 45) begin
        hi = lo + $urandom_range(0, 255);
      end else if (sel < 60) begin
        k  = $urandom_range(0, 31);
        hi = lo + ((32'sd1 <<< k) - 1 + $urandom_range(0, 2)) - 1;
      end else if (sel < 75) begin
        lo = boundary_value($urandom_range(0, 6));
        hi = (sel < 68) ? boundary_value($urandom_range(0, 6)) : $urandom;
      end
      // Wrap past the top of the signed range clamps instead.
      if (sel < 60 && hi < lo) hi = S32_MAX;
      if (lo > hi) begin
        tmp = lo; lo = hi; hi = tmp;
      end
      send_beat(REQ_DRAW, lo, hi, $urandom);
    end
  endtask

  task automatic test_random_mix(int count);
    for (int i = 0; i < count; i++) begin
      send_random_item();
      if ($urandom_range(0, 99) == 0) wait_for_results();
    end
  endtask

  // Receiver: a fresh stall count for every result beat.
  always begin : result_stall
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      out_stall <= 1'b1;
      repeat (gap) @(posedge clk);
    end
    out_stall <= 1'b0;
    @(posedge clk);
    while (!(rst_n && out_valid)) @(posedge clk);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_draws.size() == 0) begin
        $error("result beat with nothing expected: random_value %0d range_error %0b",
               out_random_value, out_range_error);
        fail_count++;
      end else begin
        head_draw = expected_draws.pop_front();
        results_checked++;
        if (out_random_value !== head_draw.value) begin
          $error("random_value: expected %0d, got %0d", head_draw.value, out_random_value);
          fail_count++;
        end
        if (out_range_error !== head_draw.range_error) begin
          $error("range_error: expected %0b, got %0b", head_draw.range_error,
                 out_range_error);
          fail_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
             expected_draws.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_draws_from_reset_seed();
    test_equal_bounds();
    test_wide_ranges();
    test_reversed_bounds();
    test_reseed();
    test_random_mix(700);
    wait_for_results();
    burst_mode = 1'b1;
    test_random_mix(300);
    wait_for_results();
    burst_mode = 1'b0;
    test_random_mix(800);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_draws.size() != 0) begin
      $error("%0d expected results never arrived", expected_draws.size());
      fail_count++;
    end
    $display("Covered %0d draws (%0d with reversed bounds) and %0d reseeds,", draws_sent,
             reversed_sent, reseeds_sent);
    $display("with random and burst handshakes; %0d results checked, %0d mismatches.",
             results_checked, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
